// File: rtl/core/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

  localparam int unsigned MAX_SEGMENTS = 16;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [31:0] SIZE_CEILING = 32'd100000000;
  localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);

  localparam logic [31:0] HEAP_LIMIT_RST = 32'd1048576;
  localparam logic [15:0] SPLIT_MIN_RST = 16'd128;
  localparam logic [26:0] LARGE_THR_RST = 27'd131072;

  localparam logic [1:0] REG_HEAP_LIMIT = 2'd0;
  localparam logic [1:0] REG_SPLIT_MIN = 2'd1;
  localparam logic [1:0] REG_LARGE_THR = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [1:0] ST_NO_MEM = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,   // latch request, clear scan
    OP_SCAN = 4'd2,   // examine entry at index, advance offset
    OP_ALLOC_HIT = 4'd3,
    OP_ALLOC_TAIL = 4'd4,
    OP_FREE_HIT = 4'd5,
    OP_SHIFT_UP = 4'd6,
    OP_SHIFT_DN = 4'd7,
    OP_COUNT = 4'd8,
    OP_DONE = 4'd9,
    OP_REWIND = 4'd10 // point the walk back at entry 0
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic scan_end;    // index reached seg_count
    logic hit;         // current entry matches the request
    logic count_end;   // recount walk finished
    logic is_alloc;
    logic need_shift_up;
    logic need_shift_dn;
    logic early_done;  // status known without table work
  } sts_t;

endpackage

// File: rtl/core/ffba_ctrl.sv
// Sequencer for the first-fit block allocator.
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ffba_pkg::sts_t  sts,
  output ffba_pkg::ctl_t  ctl
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_ACT   = 8'b0000_1000,
    S_SHIFT = 8'b0001_0000,
    S_CNT   = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_TAIL  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl.op = ffba_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.op = ffba_pkg::OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.early_done) state_nxt = S_CNT;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          if (sts.is_alloc) begin
            state_nxt = S_TAIL;
          end else begin
            ctl.op = ffba_pkg::OP_REWIND; // bad address flagged in datapath
            state_nxt = S_CNT;
          end
        end else if (sts.hit) begin
          state_nxt = S_ACT;
        end else begin
          ctl.op = ffba_pkg::OP_SCAN;
        end
      end
      S_ACT: begin
        ctl.op = sts.is_alloc ? ffba_pkg::OP_ALLOC_HIT : ffba_pkg::OP_FREE_HIT;
        state_nxt = S_SHIFT;
      end
      S_TAIL: begin
        ctl.op = ffba_pkg::OP_ALLOC_TAIL;
        state_nxt = S_CNT;
      end
      S_SHIFT: begin
        if (sts.need_shift_up) begin
          ctl.op = ffba_pkg::OP_SHIFT_UP;
        end else if (sts.need_shift_dn) begin
          ctl.op = ffba_pkg::OP_SHIFT_DN;
        end else begin
          ctl.op = ffba_pkg::OP_REWIND;
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        if (sts.count_end) begin
          ctl.op = ffba_pkg::OP_DONE;
          state_nxt = S_DONE;
        end else begin
          ctl.op = ffba_pkg::OP_COUNT;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: rtl/core/ffba_dp.sv
// Segment table, scan offset, shifter and counters of the allocator.
module ffba_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ffba_pkg::ctl_t        ctl,
  output ffba_pkg::sts_t        sts,
  input  logic                  in_command,
  input  logic [26:0]           in_req_size,
  input  logic [31:0]           in_req_addr,
  input  logic [31:0]           heap_limit,
  input  logic [15:0]           split_min,
  input  logic [26:0]           large_threshold,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [31:0]           out_grant_addr,
  output logic [4:0]            out_free_blocks,
  output logic [31:0]           out_free_bytes,
  output logic [4:0]            out_used_blocks,
  output logic [31:0]           out_used_bytes
);

  localparam int unsigned IW = ffba_pkg::IDX_W;
  localparam int unsigned CW = ffba_pkg::CNT_W;

  // table: flops, walked through a moving index
  logic [31:0] pay_r  [ffba_pkg::MAX_SEGMENTS];
  logic        fre_r  [ffba_pkg::MAX_SEGMENTS];

  logic          cmd_r;
  logic [26:0]   size_r;
  logic [31:0]   addr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;     // seg_count
  logic [CW-1:0] idx_r;              // scan / shift / count pointer
  logic [CW-1:0] hit_r;              // entry found
  logic [32:0]   off_r;              // running start offset
  logic [31:0]   heap_end_r;
  logic [1:0]    status_r;
  logic [31:0]   grant_r;
  logic          early_r;
  logic          up_r, dn_r;
  logic [CW-1:0] stop_r;             // shift end index
  logic [31:0]   ins_pay_r;          // payload placed at stop of shift up
  logic [CW-1:0] fc_r, fc_nxt;
  logic [31:0]   ft_r, ut_r;
  logic          vld_r;

  logic [IW-1:0] ix;
  logic [31:0]   cur_pay;
  logic          cur_free;
  logic [32:0]   pay_off;
  logic          alloc_hit, free_hit;
  logic [33:0]   need;
  logic [33:0]   tail_sum;
  logic [IW-1:0] lix;

  assign ix       = idx_r[IW-1:0];
  assign cur_pay  = pay_r[ix];
  assign cur_free = fre_r[ix];
  assign pay_off  = off_r + 33'(ffba_pkg::HEADER_BYTES);
  assign alloc_hit = cur_free && (cur_pay >= {5'd0, size_r});
  assign free_hit  = (pay_off == {1'b0, addr_r});
  assign need = 34'(split_min) + 34'(ffba_pkg::HEADER_BYTES) + 34'(size_r);
  assign lix = IW'(cnt_r - CW'(1));

  always_comb begin
    sts.scan_end  = (idx_r >= cnt_r);
    sts.hit       = cmd_r == ffba_pkg::CMD_ALLOC ? alloc_hit : free_hit;
    sts.count_end = (idx_r >= cnt_r);
    sts.is_alloc  = (cmd_r == ffba_pkg::CMD_ALLOC);
    sts.need_shift_up = up_r;
    sts.need_shift_dn = dn_r;
    sts.early_done = early_r;
  end

  // tail grow / append sum
  always_comb begin
    if (cnt_r != '0 && fre_r[lix])
      tail_sum = {2'b0, heap_end_r} + 34'(size_r) - 34'(pay_r[lix]);
    else
      tail_sum = {2'b0, heap_end_r} + 34'(ffba_pkg::HEADER_BYTES) + 34'(size_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      heap_end_r <= '0;
      vld_r <= 1'b0;
      up_r <= 1'b0;
      dn_r <= 1'b0;
    end else begin
      vld_r <= (ctl.op == ffba_pkg::OP_DONE);
      case (ctl.op)
        ffba_pkg::OP_LOAD: begin
          cmd_r <= in_command;
          size_r <= in_req_size;
          addr_r <= in_req_addr;
          idx_r <= '0;
          off_r <= '0;
          grant_r <= '0;
          up_r <= 1'b0;
          dn_r <= 1'b0;
          fc_r <= '0;
          ft_r <= '0;
          ut_r <= '0;
          if (in_command == ffba_pkg::CMD_ALLOC) begin
            early_r <= (in_req_size == '0) || ({5'd0, in_req_size} > ffba_pkg::SIZE_CEILING)
                       || (in_req_size >= large_threshold);
            status_r <= ((in_req_size == '0) ||
                         ({5'd0, in_req_size} > ffba_pkg::SIZE_CEILING) ||
                         (in_req_size >= large_threshold)) ? ffba_pkg::ST_BAD_SIZE
                                                           : ffba_pkg::ST_OK;
          end else begin
            early_r <= (in_req_addr == '0);
            // default to bad address; cleared on a valid hit
            status_r <= (in_req_addr == '0) ? ffba_pkg::ST_OK : ffba_pkg::ST_BAD_ADDR;
          end
        end
        ffba_pkg::OP_SCAN: begin
          idx_r <= idx_r + CW'(1);
          off_r <= off_r + 33'(ffba_pkg::HEADER_BYTES) + 33'(cur_pay);
        end
        ffba_pkg::OP_ALLOC_HIT: begin
          grant_r <= pay_off[31:0];
          status_r <= ffba_pkg::ST_OK;
          fre_r[ix] <= 1'b0;
          hit_r <= idx_r;
          if ({2'b0, cur_pay} >= need && cnt_r < CW'(ffba_pkg::MAX_SEGMENTS)) begin
            // split: move entries up from the top, then place remainder at hit+1
            pay_r[ix] <= {5'd0, size_r};
            ins_pay_r <= cur_pay - {5'd0, size_r} - ffba_pkg::HDR32;
            up_r <= 1'b1;
            stop_r <= idx_r + CW'(1);
            idx_r <= cnt_r;
            cnt_r <= cnt_r + CW'(1);
          end else begin
            stop_r <= idx_r;
          end
        end
        ffba_pkg::OP_ALLOC_TAIL: begin
          idx_r <= '0;
          if (tail_sum > {2'b0, heap_limit} ||
              (!(cnt_r != '0 && fre_r[lix]) && cnt_r >= CW'(ffba_pkg::MAX_SEGMENTS))) begin
            status_r <= ffba_pkg::ST_NO_MEM;
          end else if (cnt_r != '0 && fre_r[lix]) begin
            grant_r <= heap_end_r - pay_r[lix];
            pay_r[lix] <= {5'd0, size_r};
            fre_r[lix] <= 1'b0;
            heap_end_r <= tail_sum[31:0];
            status_r <= ffba_pkg::ST_OK;
          end else begin
            grant_r <= heap_end_r + ffba_pkg::HDR32;
            pay_r[IW'(cnt_r)] <= {5'd0, size_r};
            fre_r[IW'(cnt_r)] <= 1'b0;
            cnt_r <= cnt_r + CW'(1);
            heap_end_r <= tail_sum[31:0];
            status_r <= ffba_pkg::ST_OK;
          end
        end
        ffba_pkg::OP_FREE_HIT: begin
          if (cur_free) begin
            stop_r <= idx_r; // nothing to do, bad address stays
          end else begin
            status_r <= ffba_pkg::ST_OK;
            begin : merge
              logic nf, pf;
              logic [31:0] np;
              nf = (idx_r + CW'(1) < cnt_r) && fre_r[IW'(idx_r + CW'(1))];
              pf = (idx_r != '0) && fre_r[IW'(idx_r - CW'(1))];
              np = cur_pay + (nf ? ffba_pkg::HDR32 + pay_r[IW'(idx_r + CW'(1))] : 32'd0);
              if (pf) begin
                pay_r[IW'(idx_r - CW'(1))] <= pay_r[IW'(idx_r - CW'(1))]
                                               + ffba_pkg::HDR32 + np;
                // remove idx and (if nf) idx+1
                dn_r <= (idx_r + (nf ? CW'(2) : CW'(1))) < cnt_r;
                hit_r <= nf ? CW'(2) : CW'(1);
                cnt_r <= cnt_r - (nf ? CW'(2) : CW'(1));
                stop_r <= cnt_r - (nf ? CW'(2) : CW'(1));
              end else begin
                pay_r[ix] <= np;
                fre_r[ix] <= 1'b1;
                idx_r <= idx_r + CW'(1);
                dn_r <= nf && (idx_r + CW'(2) < cnt_r);
                hit_r <= CW'(1);
                cnt_r <= cnt_r - (nf ? CW'(1) : CW'(0));
                stop_r <= nf ? cnt_r - CW'(1) : idx_r + CW'(1);
              end
            end
          end
        end
        ffba_pkg::OP_SHIFT_UP: begin
          // idx_r counts down from old count to stop
          if (idx_r == stop_r + CW'(1)) begin
            pay_r[IW'(stop_r)] <= ins_pay_r;
            fre_r[IW'(stop_r)] <= 1'b1;
            pay_r[ix] <= pay_r[IW'(idx_r - CW'(1))];
            fre_r[ix] <= fre_r[IW'(idx_r - CW'(1))];
          end else if (idx_r == stop_r) begin
            pay_r[IW'(stop_r)] <= ins_pay_r;
            fre_r[IW'(stop_r)] <= 1'b1;
          end else begin
            pay_r[ix] <= pay_r[IW'(idx_r - CW'(1))];
            fre_r[ix] <= fre_r[IW'(idx_r - CW'(1))];
          end
          if (idx_r == stop_r + CW'(1) || idx_r == stop_r) begin
            up_r <= 1'b0;
            idx_r <= stop_r;
          end else begin
            idx_r <= idx_r - CW'(1);
          end
        end
        ffba_pkg::OP_SHIFT_DN: begin
          // move entry idx+gap to idx, hit_r holds the gap
          pay_r[ix] <= pay_r[IW'(idx_r + hit_r)];
          fre_r[ix] <= fre_r[IW'(idx_r + hit_r)];
          if (idx_r + CW'(1) >= stop_r) begin
            dn_r <= 1'b0;
            idx_r <= stop_r;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        ffba_pkg::OP_REWIND: begin
          idx_r <= '0;
        end
        ffba_pkg::OP_COUNT: begin
          idx_r <= idx_r + CW'(1);
          fc_r <= fc_nxt;
          ut_r <= ut_r + cur_pay;
          if (cur_free) ft_r <= ft_r + cur_pay;
        end
        default: ;
      endcase
    end
  end

  assign cnt_nxt = cnt_r;
  assign fc_nxt  = fc_r + CW'(cur_free);

  assign out_valid       = vld_r;
  assign out_status      = status_r;
  assign out_grant_addr  = grant_r;
  assign out_free_blocks = 5'(fc_r);
  assign out_free_bytes  = ft_r;
  assign out_used_blocks = 5'(cnt_nxt);
  assign out_used_bytes  = ut_r;

endmodule

// File: rtl/core/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator.
// Scan, table shift and recount each walk the table one entry per cycle.
// One request at a time; busy stays high through the result cycle, so the next start
// transfer comes in the cycle after the result at the earliest.
// Reset (synchronous, rst_n low) empties the table and restores register defaults.
// A result is shown for one cycle with out_valid; the receiver cannot stall it.
module first_fit_block_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [26:0] in_req_size,
  input  logic [31:0] in_req_addr,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_grant_addr,
  output logic [4:0]  out_free_blocks,
  output logic [31:0] out_free_bytes,
  output logic [4:0]  out_used_blocks,
  output logic [31:0] out_used_bytes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ffba_pkg::ctl_t ctl;
  ffba_pkg::sts_t sts;

  logic [31:0] heap_limit_r;
  logic [15:0] split_min_r;
  logic [26:0] large_thr_r;

  // config transfer only between requests, so a request sees one register set
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= ffba_pkg::HEAP_LIMIT_RST;
      split_min_r  <= ffba_pkg::SPLIT_MIN_RST;
      large_thr_r  <= ffba_pkg::LARGE_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ffba_pkg::REG_HEAP_LIMIT: heap_limit_r <= cfg_data;
        ffba_pkg::REG_SPLIT_MIN:  split_min_r  <= cfg_data[15:0];
        ffba_pkg::REG_LARGE_THR:  large_thr_r  <= cfg_data[26:0];
        default: ;
      endcase
    end
  end

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  ffba_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_command      (in_command),
    .in_req_size     (in_req_size),
    .in_req_addr     (in_req_addr),
    .heap_limit      (heap_limit_r),
    .split_min       (split_min_r),
    .large_threshold (large_thr_r),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_grant_addr  (out_grant_addr),
    .out_free_blocks (out_free_blocks),
    .out_free_bytes  (out_free_bytes),
    .out_used_blocks (out_used_blocks),
    .out_used_bytes  (out_used_bytes)
  );

endmodule

// File: sim/first_fit_block_allocator_unit_tb.sv
// Self-checking testbench for the first-fit block allocator unit.
`timescale 1ns / 1ps

module first_fit_block_allocator_unit_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  // How the driver resolves an item's address when it presents it
  typedef enum logic [1:0] {
    ADDR_FIXED,    // use req_addr as queued
    ADDR_PICK_SEG  // payload offset of a random segment of the current heap
  } addr_mode_t;

  typedef struct {
    logic        cmd;
    logic [26:0] size;
    logic [31:0] addr;
    addr_mode_t  mode;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grant;
    logic [4:0]  free_blocks;
    logic [31:0] free_bytes;
    logic [4:0]  used_blocks;
    logic [31:0] used_bytes;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_command;
  logic [26:0] in_req_size;
  logic [31:0] in_req_addr;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_grant_addr;
  logic [4:0]  out_free_blocks;
  logic [31:0] out_free_bytes;
  logic [4:0]  out_used_blocks;
  logic [31:0] out_used_bytes;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  first_fit_block_allocator_unit uut (.*);

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow heap: table, totals and register copies
  logic [31:0] heap_seg_size [ffba_pkg::MAX_SEGMENTS];
  logic        heap_seg_free [ffba_pkg::MAX_SEGMENTS];
  int unsigned heap_seg_cnt;
  logic [31:0] heap_top;
  logic [31:0] lim_heap;
  logic [31:0] lim_split;
  logic [31:0] lim_large;

  request_t pending_reqs[$];
  outcome_t expected_outcomes[$];

  logic took;      // request transfer happened at the last rising edge
  logic cfg_took;  // register transfer happened at the last rising edge
  int   idle_pct;
  int   mismatches;
  int   quiet_cycles;

  // ---------------------------------------------------------------------------
  // Heap predictor
  // ---------------------------------------------------------------------------
  task automatic heap_insert(input int unsigned pos, input logic [31:0] sz,
                             input logic fr);
    int unsigned j;
    for (j = heap_seg_cnt; j > pos; j--) begin
      heap_seg_size[j] = heap_seg_size[j-1];
      heap_seg_free[j] = heap_seg_free[j-1];
    end
    heap_seg_size[pos] = sz;
    heap_seg_free[pos] = fr;
    heap_seg_cnt++;
  endtask

  task automatic heap_remove(input int unsigned pos);
    int unsigned j;
    for (j = pos; j + 1 < heap_seg_cnt; j++) begin
      heap_seg_size[j] = heap_seg_size[j+1];
      heap_seg_free[j] = heap_seg_free[j+1];
    end
    heap_seg_cnt--;
  endtask

  task automatic heap_allocate(input logic [26:0] size, output logic [1:0] st,
                               output logic [31:0] grant);
    longint unsigned off;
    longint unsigned grow;
    longint unsigned base;
    int unsigned i;
    int unsigned last;
    off = 0;
    grant = '0;
    st = ffba_pkg::ST_OK;
    if (size == 0 || 32'(size) > ffba_pkg::SIZE_CEILING || 32'(size) >= lim_large) begin
      st = ffba_pkg::ST_BAD_SIZE;
      return;
    end
    // first fit
    for (i = 0; i < heap_seg_cnt; i++) begin
      if (heap_seg_free[i] && heap_seg_size[i] >= 32'(size)) begin
        if (64'(heap_seg_size[i]) >=
              64'(lim_split) + ffba_pkg::HEADER_BYTES + 64'(size) &&
            heap_seg_cnt < ffba_pkg::MAX_SEGMENTS) begin
          heap_insert(i + 1, heap_seg_size[i] - 32'(size) - ffba_pkg::HDR32, 1'b1);
          heap_seg_size[i] = 32'(size);
        end
        heap_seg_free[i] = 1'b0;
        grant = 32'(off + ffba_pkg::HEADER_BYTES);
        return;
      end
      off += 64'(ffba_pkg::HEADER_BYTES) + 64'(heap_seg_size[i]);
    end
    // free tail too small: grow it in place
    if (heap_seg_cnt > 0 && heap_seg_free[heap_seg_cnt-1]) begin
      last = heap_seg_cnt - 1;
      grow = 64'(size) - 64'(heap_seg_size[last]);
      base = 64'(heap_top) - ffba_pkg::HEADER_BYTES - 64'(heap_seg_size[last]);
      if (64'(heap_top) + grow > 64'(lim_heap)) begin
        st = ffba_pkg::ST_NO_MEM;
        return;
      end
      heap_seg_size[last] = 32'(size);
      heap_seg_free[last] = 1'b0;
      heap_top = 32'(64'(heap_top) + grow);
      grant = 32'(base + ffba_pkg::HEADER_BYTES);
      return;
    end
    // append
    if (heap_seg_cnt >= ffba_pkg::MAX_SEGMENTS ||
        64'(heap_top) + ffba_pkg::HEADER_BYTES + 64'(size) > 64'(lim_heap)) begin
      st = ffba_pkg::ST_NO_MEM;
      return;
    end
    heap_insert(heap_seg_cnt, 32'(size), 1'b0);
    grant = heap_top + ffba_pkg::HDR32;
    heap_top = heap_top + ffba_pkg::HDR32 + 32'(size);
  endtask

  task automatic heap_release(input logic [31:0] addr, output logic [1:0] st);
    longint unsigned off;
    int unsigned i;
    logic prev_fr;
    logic next_fr;
    off = 0;
    st = ffba_pkg::ST_OK;
    if (addr == 0) return;
    for (i = 0; i < heap_seg_cnt; i++) begin
      if (off + ffba_pkg::HEADER_BYTES == 64'(addr)) break;
      off += 64'(ffba_pkg::HEADER_BYTES) + 64'(heap_seg_size[i]);
    end
    if (i >= heap_seg_cnt || heap_seg_free[i]) begin
      st = ffba_pkg::ST_BAD_ADDR;
      return;
    end
    prev_fr = i > 0 && heap_seg_free[i-1];
    next_fr = i + 1 < heap_seg_cnt && heap_seg_free[i+1];
    if (next_fr) begin
      heap_seg_size[i] += ffba_pkg::HDR32 + heap_seg_size[i+1];
      heap_remove(i + 1);
    end
    if (prev_fr) begin
      heap_seg_size[i-1] += ffba_pkg::HDR32 + heap_seg_size[i];
      heap_remove(i);
    end else begin
      heap_seg_free[i] = 1'b1;
    end
  endtask

  task automatic predict_request(input logic cmd, input logic [26:0] size,
                                 input logic [31:0] addr, output outcome_t o);
    int unsigned i;
    o.grant = '0;
    if (cmd == ffba_pkg::CMD_ALLOC) heap_allocate(size, o.status, o.grant);
    else heap_release(addr, o.status);
    o.free_blocks = '0;
    o.free_bytes = '0;
    o.used_bytes = '0;
    for (i = 0; i < heap_seg_cnt; i++) begin
      o.used_bytes += heap_seg_size[i];
      if (heap_seg_free[i]) begin
        o.free_blocks++;
        o.free_bytes += heap_seg_size[i];
      end
    end
    o.used_blocks = 5'(heap_seg_cnt);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents requests at the falling edge, holds until transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    request_t r;
    int k;
    int unsigned pos;
    longint unsigned off;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // hold the current request
    end else if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
      r = pending_reqs.pop_front();
      if (r.mode == ADDR_PICK_SEG) begin
        // model is current: only one request is ever in flight
        if (heap_seg_cnt == 0) begin
          r.addr = ffba_pkg::HDR32;
        end else begin
          pos = $urandom_range(0, heap_seg_cnt - 1);
          off = 0;
          for (k = 0; k < pos; k++)
            off += 64'(ffba_pkg::HEADER_BYTES) + 64'(heap_seg_size[k]);
          r.addr = 32'(off + ffba_pkg::HEADER_BYTES);
        end
      end
      in_command <= r.cmd;
      in_req_size <= r.size;
      in_req_addr <= r.addr;
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: transfers, register writes, result checks and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t e;
    outcome_t a;
    if (!rst_n) begin
      took <= 1'b0;
      cfg_took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      took <= start && !busy;
      cfg_took <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ffba_pkg::REG_HEAP_LIMIT: lim_heap = cfg_data;
          ffba_pkg::REG_SPLIT_MIN:  lim_split = {16'd0, cfg_data[15:0]};
          ffba_pkg::REG_LARGE_THR:  lim_large = {5'd0, cfg_data[26:0]};
          default: ;
        endcase
      end
      if (start && !busy) begin
        predict_request(in_command, in_req_size, in_req_addr, e);
        expected_outcomes.push_back(e);
      end
      if (out_valid) begin
        a.status = out_status;
        a.grant = out_grant_addr;
        a.free_blocks = out_free_blocks;
        a.free_bytes = out_free_bytes;
        a.used_blocks = out_used_blocks;
        a.used_bytes = out_used_bytes;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: status %0d grant %0h", a.status, a.grant);
        end else begin
          e = expected_outcomes.pop_front();
          if (a != e) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: exp st %0d gr %0h fb %0d fB %0d ub %0d uB %0d",
                        " / got st %0d gr %0h fb %0d fB %0d ub %0d uB %0d"},
                       e.status, e.grant, e.free_blocks, e.free_bytes,
                       e.used_blocks, e.used_bytes, a.status, a.grant,
                       a.free_blocks, a.free_bytes, a.used_blocks, a.used_bytes);
          end
        end
      end
      // watchdog: any transfer or result counts as progress
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic cmd, input logic [26:0] size,
                           input logic [31:0] addr, input addr_mode_t mode);
    request_t r;
    r.cmd = cmd;
    r.size = size;
    r.addr = addr;
    r.mode = mode;
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  // Let the queue empty and every result arrive, then let the block settle
  task automatic drain;
    while (pending_reqs.size() > 0 || start || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int n, input int unsigned size_cap);
    int i;
    int r;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        queue_req(ffba_pkg::CMD_ALLOC, 27'($urandom_range(1, size_cap)), $urandom,
                  ADDR_FIXED);
      else if (r < 50)
        queue_req(ffba_pkg::CMD_ALLOC, 27'($urandom), $urandom, ADDR_FIXED);
      else if (r < 88)
        queue_req(ffba_pkg::CMD_FREE, 27'($urandom), 32'd0, ADDR_PICK_SEG);
      else if (r < 92)
        queue_req(ffba_pkg::CMD_FREE, 27'($urandom), 32'd0, ADDR_FIXED);
      else
        queue_req(ffba_pkg::CMD_FREE, 27'($urandom), $urandom, ADDR_FIXED);
    end
  endtask

  initial begin
    int p;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = ffba_pkg::CMD_ALLOC;
    in_req_size = '0;
    in_req_addr = '0;
    cfg_valid = 1'b0;
    cfg_index = ffba_pkg::REG_HEAP_LIMIT;
    cfg_data = '0;
    idle_pct = 0;
    mismatches = 0;
    heap_seg_cnt = 0;
    heap_top = '0;
    lim_heap = ffba_pkg::HEAP_LIMIT_RST;
    lim_split = 32'(ffba_pkg::SPLIT_MIN_RST);
    lim_large = 32'(ffba_pkg::LARGE_THR_RST);
    for (p = 0; p < ffba_pkg::MAX_SEGMENTS; p++) begin
      heap_seg_size[p] = '0;
      heap_seg_free[p] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: size limits, null and bogus frees, double free, split, merge,
    // tail growth, heap limit
    queue_req(ffba_pkg::CMD_ALLOC, 27'd0, 32'd0, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_ALLOC, 27'h7ffffff, 32'd0, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_ALLOC, 27'd131072, 32'd0, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_ALLOC, 27'd131071, 32'd0, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_ALLOC, 27'd1, 32'd0, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_ALLOC, 27'd100, 32'd0, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_FREE, 27'd0, 32'd0, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_FREE, 27'd0, 32'hffffffff, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_FREE, 27'd0, 32'd5, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_FREE, 27'd0, ffba_pkg::HDR32, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_FREE, 27'd0, ffba_pkg::HDR32, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_ALLOC, 27'd50, 32'd0, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_ALLOC, 27'd130000, 32'd0, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_FREE, 27'd0, 32'd131071 + 32'd64, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_FREE, 27'd0, 32'd131071 + 32'd64 + 32'd1 + 32'd32, ADDR_FIXED);
    queue_req(ffba_pkg::CMD_ALLOC, 27'd120000, 32'd0, ADDR_FIXED);
    for (p = 0; p < 8; p++) queue_req(ffba_pkg::CMD_ALLOC, 27'd131000, 32'd0, ADDR_FIXED);
    drain();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          idle_pct = 0;
          write_reg(ffba_pkg::REG_HEAP_LIMIT, 32'hffffffff);
          write_reg(ffba_pkg::REG_SPLIT_MIN, 32'd0);
          write_reg(ffba_pkg::REG_LARGE_THR, 32'd100000000);
        end
        1: begin
          idle_pct = 51;
          write_reg(ffba_pkg::REG_SPLIT_MIN, 32'd65535);
        end
        2: begin
          idle_pct = 12;
          write_reg(ffba_pkg::REG_HEAP_LIMIT, 32'd6000);
          write_reg(ffba_pkg::REG_SPLIT_MIN, 32'd16);
          write_reg(ffba_pkg::REG_LARGE_THR, 32'd1);
        end
        3: begin
          idle_pct = 0;
          write_reg(ffba_pkg::REG_LARGE_THR, 32'd4096);
        end
        4: begin
          idle_pct = 51;
          write_reg(ffba_pkg::REG_HEAP_LIMIT, 32'd0);
        end
        default: begin
          idle_pct = 12;
          write_reg(ffba_pkg::REG_HEAP_LIMIT, ffba_pkg::HEAP_LIMIT_RST);
          write_reg(ffba_pkg::REG_SPLIT_MIN, 32'(ffba_pkg::SPLIT_MIN_RST));
          write_reg(ffba_pkg::REG_LARGE_THR, 32'(ffba_pkg::LARGE_THR_RST));
        end
      endcase
      // a few big sizes at the widest setting, small sizes elsewhere
      if (p == 0) begin
        queue_req(ffba_pkg::CMD_ALLOC, 27'd100000000, 32'd0, ADDR_FIXED);
        queue_req(ffba_pkg::CMD_ALLOC, 27'd99999999, 32'd0, ADDR_FIXED);
      end
      queue_random(p == 2 ? 60 : 210, p == 0 ? 100000 : 600);
      drain();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
